### design/slot_priority_queue_core_defines.svh
// Assertion macros for the slot priority queue checker.
`ifndef SLOT_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SLOT_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SPQ_ASSERT_SAME(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SPQ_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

### design/spq_pkg.sv
`default_nettype none

package spq_pkg;

  localparam int SLOTS = 64;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int LEN_W = $clog2(SLOTS + 1);
  localparam int PRI_W = 8;
  localparam int PID_W = 16;
  localparam int QLEN_W = 7;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [QLEN_W-1:0] QLEN_RESET = QLEN_W'(64);
  localparam logic [ADDR_W-1:0] ADDR_QUEUE_LENGTH = ADDR_W'(0);

  typedef enum logic {
    KIND_INSERT  = 1'b0,
    KIND_EXTRACT = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    kind_t             kind;
    logic [PRI_W-1:0]  priority_req;
    logic [PID_W-1:0]  process_id;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [PID_W-1:0]  out_process_id;
    logic [PRI_W-1:0]  out_priority;
    logic              is_full;
    logic              is_empty;
    logic [LEN_W-1:0]  entry_count;
  } rsp_t;

  // One table entry as held in the slot memory.
  typedef struct packed {
    logic [PRI_W-1:0]  pri;
    logic [PID_W-1:0]  pid;
  } entry_t;

  // Tag that travels alongside a memory read.
  typedef struct packed {
    logic              valid;
    logic              used;
    logic [IDX_W-1:0]  idx;
  } scan_tag_t;

  // Running pick of the scan.
  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  idx;
    entry_t            entry;
  } scan_best_t;

endpackage

`default_nettype wire

### design/slot_priority_queue_core.sv
// Flow: an accepted word scans slots 0 to L - 1 through the single read port of the slot memory,
// one slot per cycle, L the effective length (no scan runs when it is zero), then returns its
// result. busy stays high until the word is done, so a new word is accepted only after the
// last one has finished.
// Reset: all slots free, entry count zero, queue_length back to 64; the slot memory
// itself is not cleared. Results are strobed for one cycle and cannot be stalled.
`default_nettype none

module slot_priority_queue_core (
  input  wire                          clk,
  input  wire                          rst,
  // command channel
  input  wire                          start,
  output logic                         busy,
  input  spq_pkg::req_t                req,
  // result strobe
  output logic                         rsp_valid,
  output spq_pkg::rsp_t                rsp,
  // configuration port
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [spq_pkg::ADDR_W-1:0]    paddr,
  input  wire [spq_pkg::DATA_W-1:0]    pwdata,
  output logic [spq_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t                        state;
  spq_pkg::kind_t                kind;
  spq_pkg::entry_t               ins_entry;
  logic [spq_pkg::LEN_W-1:0]     len;
  logic [spq_pkg::IDX_W-1:0]     idx;
  logic [spq_pkg::LEN_W-1:0]     count;
  logic [spq_pkg::LEN_W-1:0]     count_next;
  logic [spq_pkg::QLEN_W-1:0]    queue_length;
  logic [spq_pkg::LEN_W-1:0]     len_eff;
  logic                          slot_used [spq_pkg::SLOTS];
  logic                          accept;
  logic                          last;
  logic                          cfg_wr;
  logic                          mem_wr;
  spq_pkg::scan_tag_t            tag;
  spq_pkg::entry_t               rd_data;
  spq_pkg::scan_best_t           best;
  spq_pkg::status_t              status_next;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == spq_pkg::ADDR_QUEUE_LENGTH);

  // Clamp the programmed length to the table size.
  always_comb begin
    if (spq_pkg::LEN_W'(queue_length) > spq_pkg::LEN_W'(spq_pkg::SLOTS)) begin
      len_eff = spq_pkg::LEN_W'(spq_pkg::SLOTS);
    end else begin
      len_eff = spq_pkg::LEN_W'(queue_length);
    end
  end

  // Last slot of the scan is issued when idx reaches len - 1.
  assign last = (spq_pkg::LEN_W'(idx) == (len - spq_pkg::LEN_W'(1)));

  always_comb begin
    if (paddr == spq_pkg::ADDR_QUEUE_LENGTH) begin
      prdata = spq_pkg::DATA_W'(queue_length);
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_length <= spq_pkg::QLEN_RESET;
    end else if (cfg_wr) begin
      queue_length <= pwdata[spq_pkg::QLEN_W-1:0];
    end
  end

  // Outcome of the finished scan: status and the count left behind.
  always_comb begin
    count_next  = count;
    status_next = spq_pkg::STATUS_OK;
    if (kind == spq_pkg::KIND_INSERT) begin
      if (best.found) begin
        count_next = count + spq_pkg::LEN_W'(1);
      end else begin
        status_next = spq_pkg::STATUS_FULL;
      end
    end else begin
      if (best.found) begin
        if (count != '0) begin
          count_next = count - spq_pkg::LEN_W'(1);
        end
      end else begin
        status_next = spq_pkg::STATUS_EMPTY;
      end
    end
  end

  assign mem_wr = (state == ST_FINISH) && (kind == spq_pkg::KIND_INSERT) && best.found;

  // Slot memory: one read per scan cycle, one write at the end of a successful insert.
  spq_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (best.idx),
    .wr_data (ins_entry),
    .rd_en   (state == ST_SCAN),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  // Compare stage sees each slot in the cycle after its read was issued.
  spq_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .clear   (accept),
    .kind    (kind),
    .tag     (tag),
    .rd_data (rd_data),
    .best    (best)
  );

  // Occupancy bits: cleared at once by reset, updated only when a word finishes.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < spq_pkg::SLOTS; i++) begin
        slot_used[i] <= 1'b0;
      end
    end else if ((state == ST_FINISH) && best.found) begin
      slot_used[best.idx] <= (kind == spq_pkg::KIND_INSERT);
    end
  end

  // Sequencer and registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
      tag.valid <= 1'b0;
    end else begin
      rsp_valid <= (state == ST_FINISH);
      tag.valid <= (state == ST_SCAN);
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            // An empty window has nothing to scan: go straight to the result.
            state <= (len_eff == '0) ? ST_FINISH : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          count <= count_next;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end

    // Payload registers: no reset.
    tag.idx  <= idx;
    tag.used <= slot_used[idx];
    if (accept) begin
      kind          <= req.kind;
      ins_entry.pri <= req.priority_req;
      ins_entry.pid <= req.process_id;
      len           <= len_eff;
      idx           <= '0;
    end else if (state == ST_SCAN) begin
      idx <= idx + spq_pkg::IDX_W'(1);
    end
    if (state == ST_FINISH) begin
      rsp.status      <= status_next;
      rsp.is_full     <= (count_next >= len);
      rsp.is_empty    <= (count_next == '0);
      rsp.entry_count <= count_next;
      if ((kind == spq_pkg::KIND_EXTRACT) && best.found) begin
        rsp.out_process_id <= best.entry.pid;
        rsp.out_priority   <= best.entry.pri;
      end else begin
        rsp.out_process_id <= '0;
        rsp.out_priority   <= '0;
      end
    end
  end

endmodule

`default_nettype wire

### design/spq_mem.sv
`default_nettype none

module spq_mem (
  input  wire                         clk,
  input  wire                         wr_en,
  input  wire [spq_pkg::IDX_W-1:0]    wr_addr,
  input  spq_pkg::entry_t             wr_data,
  input  wire                         rd_en,
  input  wire [spq_pkg::IDX_W-1:0]    rd_addr,
  output spq_pkg::entry_t             rd_data
);

  spq_pkg::entry_t mem [spq_pkg::SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### design/spq_scan.sv
`default_nettype none

module spq_scan (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 clear,
  input  spq_pkg::kind_t      kind,
  input  spq_pkg::scan_tag_t  tag,
  input  spq_pkg::entry_t     rd_data,
  output spq_pkg::scan_best_t best
);

  logic hit;

  // Insert wants the first free slot; extract wants the used slot of highest priority, the first winning a tie.
  always_comb begin
    if (kind == spq_pkg::KIND_EXTRACT) begin
      hit = tag.valid && tag.used && (!best.found || (rd_data.pri > best.entry.pri));
    end else begin
      hit = tag.valid && !tag.used && !best.found;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      best.found <= 1'b0;
    end else if (hit) begin
      best.found <= 1'b1;
    end
    if (hit) begin
      best.idx   <= tag.idx;
      best.entry <= rd_data;
    end
  end

endmodule

`default_nettype wire

### design/spq_checker.sv
`default_nettype none
`include "slot_priority_queue_core_defines.svh"

module spq_checker (
  input wire            clk,
  input wire            rst,
  input wire            start,
  input wire            busy,
  input wire            rsp_valid,
  input spq_pkg::rsp_t  rsp
);

  `SPQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `SPQ_ASSERT_NEXT(a_strobe_single, rsp_valid, !rsp_valid, "result strobe held two cycles")
  `SPQ_ASSERT_SAME(a_empty_count, rsp_valid && rsp.is_empty, rsp.entry_count == '0, "empty with entries")
  `SPQ_ASSERT_SAME(a_fail_zero, rsp_valid && (rsp.status != spq_pkg::STATUS_OK), (rsp.out_process_id == '0) && (rsp.out_priority == '0), "failed word returned data")

endmodule

bind slot_priority_queue_core spq_checker u_spq_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .rsp_valid (rsp_valid),
  .rsp       (rsp)
);

`default_nettype wire
